@@ rtl/h2fd_pkg.sv @@
// Shared types, constants and helper functions of the HTTP/2 frame deframer.
package h2fd_pkg;

    localparam int unsigned DefStreamSlots = 32;

    localparam logic [4:0]  PrefaceLast = 5'd23;
    localparam logic [30:0] WinMax      = 31'h7fffffff;
    localparam logic [30:0] WinInit     = 31'd65535;

    // Frame type codes
    localparam logic [7:0] T_HEADERS  = 8'h1;
    localparam logic [7:0] T_RST      = 8'h3;
    localparam logic [7:0] T_SETTINGS = 8'h4;
    localparam logic [7:0] T_PING     = 8'h6;
    localparam logic [7:0] T_GOAWAY   = 8'h7;
    localparam logic [7:0] T_WINUPD   = 8'h8;

    // Connection phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PREFACE = 2'd1;
    localparam logic [1:0] PH_OPEN    = 2'd2;
    localparam logic [1:0] PH_CLOSED  = 2'd3;

    // Touched stream report codes
    localparam logic [1:0] TS_NONE   = 2'd0;
    localparam logic [1:0] TS_OPEN   = 2'd1;
    localparam logic [1:0] TS_CLOSED = 2'd2;

    // Configuration register index
    localparam logic REG_ROLE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ADD,
        S_GRD,
        S_GCMP
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_STREAM,
        OP_GOAWAY
    } op_t;

    typedef struct packed {
        logic clear;
        logic role;
        logic accept;
        logic rd;
        logic upd;
        logic add;
        logic gsw;
        logic idx_inc;
        logic post;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic idx_end;
        logic hit;
        logic res_busy;
    } sts_t;

    // First 32-bit word of the control payload (up to 8 bytes, right aligned)
    function automatic logic [31:0] word0(input logic [63:0] ctl, input logic [23:0] tot);
        logic [31:0] w;
        begin
            w = 32'd0;
            if (tot >= 24'd8)
            begin
                w = ctl[63:32];
            end
            else
            begin
                case (tot[2:0])
                    3'd7:    w = ctl[55:24];
                    3'd6:    w = ctl[47:16];
                    3'd5:    w = ctl[39:8];
                    3'd4:    w = ctl[31:0];
                    default: w = 32'd0;
                endcase
            end
            return w;
        end
    endfunction

    // Window add with saturation at the largest 31-bit value
    function automatic logic [30:0] win_add(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[31] ? WinMax : s[30:0];
        end
    endfunction

endpackage

@@ rtl/http2_frame_deframer.sv @@
// HTTP/2 frame deframer: byte-serial frame header parser with a bounded stream table.
//
// Input channel (in_valid/in_stall/in_byte) takes one connection byte per transfer.
// Output channel (out_valid/out_stall plus result fields) gives one result per byte.
// Role is set through the APB port at byte addresses 0 to 3; any write there also
// restarts the parser and empties the stream table.
// An ordinary byte is parsed into the result stage, then moved to the output
// register when the output register is empty or not stalled.
// A HEADERS frame end, or a stream reset or WINDOW_UPDATE frame end with 4 or more
// payload bytes and a nonzero stream id, searches the stream table entry by entry
// (read then compare on the single table port); GOAWAY (8+ payload bytes) sweeps all.
// The result stage and the output register form a skid pair: a new byte is taken while
// the output is stalled, if the result stage is free and no table work is running.
// Reset puts the block in server role with the parser at the preface and an
// empty stream table; no clearing pass is needed.
module http2_frame_deframer #(
    parameter int unsigned STREAM_SLOTS = h2fd_pkg::DefStreamSlots
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        byte_is_payload,
    output logic [7:0]  payload_byte,
    output logic        frame_done,
    output logic [7:0]  frame_kind,
    output logic [7:0]  frame_flag_bits,
    output logic [30:0] frame_stream,
    output logic        want_settings_ack,
    output logic        want_ping_ack,
    output logic [1:0]  link_state,
    output logic [31:0] last_error,
    output logic [1:0]  touched_stream_state,
    output logic [30:0] touched_recv_window
);

    h2fd_pkg::cmd_t cmd;
    h2fd_pkg::sts_t sts;

    h2fd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    h2fd_datapath #(
        .STREAM_SLOTS (STREAM_SLOTS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .in_byte              (in_byte),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .byte_is_payload      (byte_is_payload),
        .payload_byte         (payload_byte),
        .frame_done           (frame_done),
        .frame_kind           (frame_kind),
        .frame_flag_bits      (frame_flag_bits),
        .frame_stream         (frame_stream),
        .want_settings_ack    (want_settings_ack),
        .want_ping_ack        (want_ping_ack),
        .link_state           (link_state),
        .last_error           (last_error),
        .touched_stream_state (touched_stream_state),
        .touched_recv_window  (touched_recv_window)
    );

endmodule

@@ rtl/h2fd_ctrl.sv @@
// Controller: configuration port, sequencing state machine for table work.
module h2fd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  h2fd_pkg::sts_t    sts,
    output h2fd_pkg::cmd_t    cmd
);

    h2fd_pkg::state_t state_reg, state_next;
    logic role_reg, role_next;
    logic wr_role;

    assign pready  = 1'b1;
    assign wr_role = psel && penable && pwrite && (paddr[2] == h2fd_pkg::REG_ROLE);
    assign prdata  = (paddr[2] == h2fd_pkg::REG_ROLE) ? {31'd0, role_reg} : 32'd0;
    assign role_next = wr_role ? pwdata[0] : role_reg;

    // State and role registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= h2fd_pkg::S_IDLE;
            role_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            role_reg  <= role_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.role    = role_next;
        cmd.clear   = wr_role;
        in_stall    = 1'b1;
        unique case (state_reg)
            h2fd_pkg::S_IDLE:
            begin
                in_stall = sts.res_busy;
                if (in_valid && !sts.res_busy)
                begin
                    cmd.accept = 1'b1;
                    if (sts.op == h2fd_pkg::OP_STREAM)
                    begin
                        state_next = h2fd_pkg::S_RD;
                    end
                    else if (sts.op == h2fd_pkg::OP_GOAWAY)
                    begin
                        state_next = h2fd_pkg::S_GRD;
                    end
                end
            end
            h2fd_pkg::S_RD:
            begin
                if (sts.idx_end)
                begin
                    state_next = h2fd_pkg::S_ADD;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = h2fd_pkg::S_CMP;
                end
            end
            h2fd_pkg::S_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.upd    = 1'b1;
                    cmd.post   = 1'b1;
                    state_next = h2fd_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = h2fd_pkg::S_RD;
                end
            end
            h2fd_pkg::S_ADD:
            begin
                cmd.add    = 1'b1;
                cmd.post   = 1'b1;
                state_next = h2fd_pkg::S_IDLE;
            end
            h2fd_pkg::S_GRD:
            begin
                if (sts.idx_end)
                begin
                    cmd.post   = 1'b1;
                    state_next = h2fd_pkg::S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = h2fd_pkg::S_GCMP;
                end
            end
            h2fd_pkg::S_GCMP:
            begin
                cmd.gsw     = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = h2fd_pkg::S_GRD;
            end
            default:
            begin
                state_next = h2fd_pkg::S_IDLE;
            end
        endcase
        if (wr_role)
        begin
            state_next = h2fd_pkg::S_IDLE;
            cmd.accept = 1'b0;
        end
    end

endmodule

@@ rtl/h2fd_datapath.sv @@
// Datapath: byte parser registers, stream table memory, result and output registers.
module h2fd_datapath #(
    parameter int unsigned STREAM_SLOTS = h2fd_pkg::DefStreamSlots
) (
    input  logic              clk,
    input  logic              rst_n,
    input  h2fd_pkg::cmd_t    cmd,
    output h2fd_pkg::sts_t    sts,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              byte_is_payload,
    output logic [7:0]        payload_byte,
    output logic              frame_done,
    output logic [7:0]        frame_kind,
    output logic [7:0]        frame_flag_bits,
    output logic [30:0]       frame_stream,
    output logic              want_settings_ack,
    output logic              want_ping_ack,
    output logic [1:0]        link_state,
    output logic [31:0]       last_error,
    output logic [1:0]        touched_stream_state,
    output logic [30:0]       touched_recv_window
);

    localparam int unsigned IW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(STREAM_SLOTS + 1);
    localparam logic [CW-1:0] SlotsFull = CW'(STREAM_SLOTS);

    typedef struct packed {
        logic        pay;
        logic [7:0]  pbyte;
        logic        done;
        logic [7:0]  kind;
        logic [7:0]  flags;
        logic [30:0] sid;
        logic        sack;
        logic        pack;
        logic [1:0]  link;
        logic [31:0] err;
        logic [1:0]  tstate;
        logic [30:0] twin;
    } res_t;

    // Parser state
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  pcnt_reg, pcnt_next;
    logic        inpay_reg, inpay_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [47:0] hdr_reg, hdr_next;
    logic [23:0] tot_reg, tot_next;
    logic [23:0] seen_reg, seen_next;
    logic [63:0] ctl_reg, ctl_next;
    logic [31:0] err_reg, err_next;
    h2fd_pkg::op_t op_next;
    res_t        acc_res;

    // Table control
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [30:0]   rd_id_reg;
    logic          rd_closed_reg;
    logic [30:0]   rd_win_reg;

    // Result staging
    res_t res_reg, out_reg;
    logic res_valid_reg, out_valid_reg;
    logic move;

    // Stream table memories
    logic [30:0] ids_mem    [STREAM_SLOTS];
    logic        closed_mem [STREAM_SLOTS];
    logic [30:0] win_mem    [STREAM_SLOTS];

    logic [30:0] sid;
    logic [7:0]  kind;
    logic [31:0] w0;
    logic [30:0] add_win, upd_win;
    logic        full;

    logic          cl_we, cl_wd;
    logic          win_we;
    logic [30:0]   win_wd;
    logic          id_we;
    logic [IW-1:0] wr_addr;
    logic [1:0]    tst;
    logic [30:0]   twn;

    assign sid     = hdr_reg[30:0];
    assign kind    = hdr_reg[47:40];
    assign w0      = h2fd_pkg::word0(ctl_reg, tot_reg);
    assign full    = (count_reg == SlotsFull);
    assign add_win = (kind == h2fd_pkg::T_WINUPD) ? h2fd_pkg::win_add(h2fd_pkg::WinInit, w0[30:0])
                                                  : h2fd_pkg::WinInit;
    assign upd_win = (kind == h2fd_pkg::T_WINUPD) ? h2fd_pkg::win_add(rd_win_reg, w0[30:0])
                                                  : rd_win_reg;

    assign sts.op       = op_next;
    assign sts.idx_end  = (idx_reg == count_reg);
    assign sts.hit      = (rd_id_reg == sid);
    assign sts.res_busy = res_valid_reg;

    // Per-byte parse of the accepted transfer
    always_comb
    begin
        logic        done;
        logic        show;
        logic [31:0] aw0;
        logic [30:0] nsid;
        logic [7:0]  nflags;
        logic [7:0]  nkind;
        phase_next = phase_reg;
        pcnt_next  = pcnt_reg;
        inpay_next = inpay_reg;
        hcnt_next  = hcnt_reg;
        hdr_next   = hdr_reg;
        tot_next   = tot_reg;
        seen_next  = seen_reg;
        ctl_next   = ctl_reg;
        err_next   = err_reg;
        op_next    = h2fd_pkg::OP_NONE;
        done       = 1'b0;
        show       = 1'b0;
        acc_res    = '0;
        if ((phase_reg == h2fd_pkg::PH_IDLE) && !cmd.role)
        begin
            if (pcnt_reg == h2fd_pkg::PrefaceLast)
            begin
                pcnt_next  = 5'd0;
                phase_next = h2fd_pkg::PH_PREFACE;
            end
            else
            begin
                pcnt_next = pcnt_reg + 5'd1;
            end
        end
        else if (!inpay_reg)
        begin
            if (hcnt_reg < 4'd3)
            begin
                tot_next = {tot_reg[15:0], in_byte};
            end
            hdr_next = {hdr_reg[39:0], in_byte};
            if (hcnt_reg == 4'd8)
            begin
                hcnt_next = 4'd0;
                seen_next = 24'd0;
                ctl_next  = 64'd0;
                if (tot_next == 24'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    inpay_next = 1'b1;
                end
                show = 1'b1;
            end
            else
            begin
                hcnt_next = hcnt_reg + 4'd1;
            end
        end
        else
        begin
            acc_res.pay   = 1'b1;
            acc_res.pbyte = in_byte;
            if (seen_reg < 24'd8)
            begin
                ctl_next = {ctl_reg[55:0], in_byte};
            end
            seen_next = seen_reg + 24'd1;
            if (seen_next == tot_reg)
            begin
                inpay_next = 1'b0;
                done       = 1'b1;
            end
            show = 1'b1;
        end

        nkind  = hdr_next[47:40];
        nflags = hdr_next[39:32];
        nsid   = hdr_next[30:0];
        aw0    = h2fd_pkg::word0(ctl_next, tot_next);
        if (show && (inpay_next || done))
        begin
            acc_res.kind  = nkind;
            acc_res.flags = nflags;
            acc_res.sid   = nsid;
        end
        // Frame-end action by type
        if (done)
        begin
            acc_res.done = 1'b1;
            case (nkind)
                h2fd_pkg::T_SETTINGS:
                begin
                    acc_res.sack = !nflags[0] && !cmd.role;
                    phase_next   = h2fd_pkg::PH_OPEN;
                end
                h2fd_pkg::T_PING:
                begin
                    acc_res.pack = !nflags[0];
                end
                h2fd_pkg::T_HEADERS:
                begin
                    op_next = h2fd_pkg::OP_STREAM;
                end
                h2fd_pkg::T_RST:
                begin
                    if ((tot_next >= 24'd4) && (nsid != 31'd0))
                    begin
                        op_next = h2fd_pkg::OP_STREAM;
                        if (err_reg == 32'd0)
                        begin
                            err_next = aw0;
                        end
                    end
                end
                h2fd_pkg::T_WINUPD:
                begin
                    if ((tot_next >= 24'd4) && (nsid != 31'd0))
                    begin
                        op_next = h2fd_pkg::OP_STREAM;
                    end
                end
                h2fd_pkg::T_GOAWAY:
                begin
                    if (tot_next >= 24'd8)
                    begin
                        op_next    = h2fd_pkg::OP_GOAWAY;
                        err_next   = ctl_next[31:0];
                        phase_next = h2fd_pkg::PH_CLOSED;
                    end
                end
                default:
                begin
                end
            endcase
        end
        acc_res.link = phase_next;
        acc_res.err  = err_next;
    end

    // Table write port and touched-entry report
    always_comb
    begin
        cl_we   = 1'b0;
        cl_wd   = 1'b0;
        win_we  = 1'b0;
        win_wd  = upd_win;
        id_we   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        tst     = h2fd_pkg::TS_NONE;
        twn     = 31'd0;
        if (cmd.upd)
        begin
            win_we = 1'b1;
            cl_we  = 1'b1;
            cl_wd  = rd_closed_reg;
            if (kind == h2fd_pkg::T_HEADERS)
            begin
                cl_wd = 1'b0;
            end
            else if (kind == h2fd_pkg::T_RST)
            begin
                cl_wd = 1'b1;
            end
            tst = cl_wd ? h2fd_pkg::TS_CLOSED : h2fd_pkg::TS_OPEN;
            twn = upd_win;
        end
        else if (cmd.add && !full)
        begin
            id_we   = 1'b1;
            cl_we   = 1'b1;
            win_we  = 1'b1;
            wr_addr = count_reg[IW-1:0];
            cl_wd   = (kind == h2fd_pkg::T_RST);
            win_wd  = add_win;
            tst     = cl_wd ? h2fd_pkg::TS_CLOSED : h2fd_pkg::TS_OPEN;
            twn     = add_win;
        end
        else if (cmd.gsw)
        begin
            cl_we = (rd_id_reg > w0[30:0]);
            cl_wd = 1'b1;
        end
    end

    // Stream table memory
    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            ids_mem[wr_addr] <= sid;
        end
        if (cl_we)
        begin
            closed_mem[wr_addr] <= cl_wd;
        end
        if (win_we)
        begin
            win_mem[wr_addr] <= win_wd;
        end
        if (cmd.rd)
        begin
            rd_id_reg     <= ids_mem[idx_reg[IW-1:0]];
            rd_closed_reg <= closed_mem[idx_reg[IW-1:0]];
            rd_win_reg    <= win_mem[idx_reg[IW-1:0]];
        end
    end

    assign move = res_valid_reg && (!out_valid_reg || !out_stall);

    // Payload of the result and output stages
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_reg <= acc_res;
        end
        else if (cmd.upd || cmd.add)
        begin
            res_reg.tstate <= tst;
            res_reg.twin   <= twn;
        end
        if (move)
        begin
            out_reg <= res_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= h2fd_pkg::PH_IDLE;
            pcnt_reg      <= 5'd0;
            inpay_reg     <= 1'b0;
            hcnt_reg      <= 4'd0;
            hdr_reg       <= 48'd0;
            tot_reg       <= 24'd0;
            seen_reg      <= 24'd0;
            ctl_reg       <= 64'd0;
            err_reg       <= 32'd0;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            phase_reg     <= cmd.role ? h2fd_pkg::PH_PREFACE : h2fd_pkg::PH_IDLE;
            pcnt_reg      <= 5'd0;
            inpay_reg     <= 1'b0;
            hcnt_reg      <= 4'd0;
            hdr_reg       <= 48'd0;
            tot_reg       <= 24'd0;
            seen_reg      <= 24'd0;
            ctl_reg       <= 64'd0;
            err_reg       <= 32'd0;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                pcnt_reg  <= pcnt_next;
                inpay_reg <= inpay_next;
                hcnt_reg  <= hcnt_next;
                hdr_reg   <= hdr_next;
                tot_reg   <= tot_next;
                seen_reg  <= seen_next;
                ctl_reg   <= ctl_next;
                err_reg   <= err_next;
                idx_reg   <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.add && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if ((cmd.accept && (op_next == h2fd_pkg::OP_NONE)) || cmd.post)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                res_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign byte_is_payload      = out_reg.pay;
    assign payload_byte         = out_reg.pbyte;
    assign frame_done           = out_reg.done;
    assign frame_kind           = out_reg.kind;
    assign frame_flag_bits      = out_reg.flags;
    assign frame_stream         = out_reg.sid;
    assign want_settings_ack    = out_reg.sack;
    assign want_ping_ack        = out_reg.pack;
    assign link_state           = out_reg.link;
    assign last_error           = out_reg.err;
    assign touched_stream_state = out_reg.tstate;
    assign touched_recv_window  = out_reg.twin;

endmodule

@@ rtl/h2fd_checker.sv @@
// Port-level checks of the deframer, bound to the top level.
module h2fd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        byte_is_payload,
    input logic [7:0]  payload_byte,
    input logic        frame_done,
    input logic        want_settings_ack,
    input logic        want_ping_ack,
    input logic [1:0]  touched_stream_state
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled payload byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(payload_byte))
        else $error("stalled payload changed");

    // One byte at a time: an accepted transfer stalls the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !(psel && penable && pwrite) |=> in_stall)
        else $error("second byte taken before result staged");

    // Non-payload results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_is_payload |-> payload_byte == 8'd0)
        else $error("payload byte on a non-payload result");

    // Frame-end reports only on frame-ending results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |->
            !want_settings_ack && !want_ping_ack && touched_stream_state == 2'd0)
        else $error("frame-end report without frame end");

endmodule

bind http2_frame_deframer h2fd_checker u_h2fd_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .byte_is_payload      (byte_is_payload),
    .payload_byte         (payload_byte),
    .frame_done           (frame_done),
    .want_settings_ack    (want_settings_ack),
    .want_ping_ack        (want_ping_ack),
    .touched_stream_state (touched_stream_state)
);
